FILE: design/lmsanc_pkg.sv
// shared constants for the lms adaptive noise canceller
`timescale 1ns / 1ps
`default_nettype none

package lmsanc_pkg;

  localparam int TAPS_DEF    = 32;
  localparam int SAMPLE_W    = 16;
  localparam int STEP_W      = 15;
  localparam int ACC_W       = 32;
  localparam int Q_BITS      = 15;
  localparam int Q_HALF      = 1 << (Q_BITS - 1);
  localparam int MUL_A_W     = ACC_W;
  localparam int MUL_B_W     = SAMPLE_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(16);

endpackage

`default_nettype wire

FILE: design/lms_adaptive_noise_canceller_core.sv
// top level of the lms adaptive noise canceller: sequencer, sample and weight memories
`timescale 1ns / 1ps
`default_nettype none

// the error transfer is offered after the dot-product pass, and a new input item is taken only
//   once the weight update pass of the last one is done; one shared 32x17 multiplier does the
//   TAPS dot-product products, the step scaling and the TAPS weight updates in turn, and a held
//   result adds its stall cycles before the step scaling
// reset (rst_n low, synchronous): delay lines and weights read as zero through valid bits,
//   step size back to 16, no result pending; no clearing pass is needed

module lms_adaptive_noise_canceller_core
  import lmsanc_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // input channel
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [31:0]         in_tdata,    // [15:0] desired_sample, [31:16] reference_sample
  // result channel
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [31:0]         out_tdata,   // [31:0] error_sample
  // step size register
  input  wire                 cfg_wr_en,
  input  wire  [STEP_W-1:0]   cfg_wr_data
);

  localparam int AW = $clog2(TAPS);
  localparam int CW = $clog2(TAPS + 1);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_ERR   = 6'b000100,
    S_SCL   = 6'b001000,
    S_SWAIT = 6'b010000,
    S_UPD   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // sample and weight storage
  logic [SAMPLE_W-1:0] des_mem [TAPS];
  logic [SAMPLE_W-1:0] ref_mem [TAPS];
  logic [ACC_W-1:0]    w_mem   [TAPS];
  logic [TAPS-1:0]     line_vld_r;
  logic [TAPS-1:0]     w_vld_r;

  logic [AW-1:0]       ptr_r;        // slot for the next sample; after a write, the oldest
  logic [AW-1:0]       ptr_inc;
  logic [AW-1:0]       ra_r;         // reference slot of the tap being read
  logic [AW-1:0]       widx_r;       // weight index of the tap being read
  logic [CW-1:0]       iss_cnt_r;    // taps issued in this pass
  logic [AW-1:0]       res_cnt_r;    // products returned in this pass

  logic [SAMPLE_W-1:0] ref_q_r;
  logic                ref_ok_r;
  logic [ACC_W-1:0]    w_q_r;
  logic                w_ok_r;
  logic [SAMPLE_W-1:0] des_q_r;
  logic                des_ok_r;
  logic                rd_vld_r;

  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    err_r;
  logic [ACC_W-1:0]    scaled_r;
  logic [ACC_W-1:0]    w_d1_r;
  logic [ACC_W-1:0]    w_d2_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_vld_r;
  logic [ACC_W-1:0]    out_data_r;

  logic                in_xfer;
  logic                issuing;
  logic                pass_last;
  logic                err_load;
  logic [SAMPLE_W-1:0] ref_val;
  logic [ACC_W-1:0]    w_val;
  logic [ACC_W-1:0]    des_val;

  // shared multiplier port
  logic                mul_in_vld;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                mul_out_vld;
  logic [ACC_W-1:0]    mul_q;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign ptr_inc   = (ptr_r == AW'(TAPS - 1)) ? '0 : ptr_r + 1'b1;

  // one tap read per cycle in either pass until all TAPS are issued
  assign issuing   = ((state_r == S_MAC) || (state_r == S_UPD)) && (iss_cnt_r != CW'(TAPS));
  assign pass_last = mul_out_vld && (res_cnt_r == AW'(TAPS - 1));
  assign err_load  = (state_r == S_ERR) && (!out_vld_r || out_tready);

  // entries never written since reset read as zero
  assign ref_val = ref_ok_r ? ref_q_r : '0;
  assign w_val   = w_ok_r ? w_q_r : '0;
  assign des_val = des_ok_r ? {{(ACC_W-SAMPLE_W){des_q_r[SAMPLE_W-1]}}, des_q_r} : '0;

  // operand select: error times doubled step, or weight / scaled error times reference
  always_comb begin
    mul_in_vld = rd_vld_r;
    mul_a      = (state_r == S_UPD) ? scaled_r : w_val;
    mul_b      = {ref_val[SAMPLE_W-1], ref_val};
    if (state_r == S_SCL) begin
      mul_in_vld = 1'b1;
      mul_a      = err_r;
      mul_b      = {1'b0, step_r, 1'b0};
    end
  end

  lmsanc_q15mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (mul_in_vld),
    .op_a      (mul_a),
    .op_b      (mul_b),
    .res_valid (mul_out_vld),
    .res_q     (mul_q)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_MAC;
      S_MAC:   if (pass_last) state_nxt = S_ERR;
      S_ERR:   if (err_load) state_nxt = S_SCL;
      S_SCL:   state_nxt = S_SWAIT;
      S_SWAIT: if (mul_out_vld) state_nxt = S_UPD;
      S_UPD:   if (pass_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories: one write and registered reads per cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      des_mem[ptr_r] <= in_tdata[15:0];
      ref_mem[ptr_r] <= in_tdata[31:16];
    end
    if ((state_r == S_UPD) && mul_out_vld) begin
      w_mem[res_cnt_r] <= w_d2_r + mul_q;
    end
    ref_q_r  <= ref_mem[ra_r];
    ref_ok_r <= line_vld_r[ra_r];
    w_q_r    <= w_mem[widx_r];
    w_ok_r   <= w_vld_r[widx_r];
    des_q_r  <= des_mem[ptr_r];
    des_ok_r <= line_vld_r[ptr_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    w_d1_r <= w_val;
    w_d2_r <= w_d1_r;
    if (in_xfer) begin
      acc_r <= '0;
    end else if ((state_r == S_MAC) && mul_out_vld) begin
      acc_r <= acc_r + mul_q;
    end
    if (err_load) begin
      err_r      <= des_val - acc_r;
      out_data_r <= des_val - acc_r;
    end
    if ((state_r == S_SWAIT) && mul_out_vld) begin
      scaled_r <= mul_q;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      line_vld_r <= '0;
      w_vld_r    <= '0;
      ptr_r      <= '0;
      ra_r       <= '0;
      widx_r     <= '0;
      iss_cnt_r  <= '0;
      res_cnt_r  <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      step_r     <= STEP_RESET;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issuing;
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        line_vld_r[ptr_r] <= 1'b1;
        ptr_r             <= ptr_inc;
        ra_r              <= ptr_inc;   // tap 0 is the oldest sample
        widx_r            <= '0;
        iss_cnt_r         <= '0;
        res_cnt_r         <= '0;
      end
      if (issuing) begin
        ra_r      <= (ra_r == AW'(TAPS - 1)) ? '0 : ra_r + 1'b1;
        widx_r    <= (widx_r == AW'(TAPS - 1)) ? '0 : widx_r + 1'b1;
        iss_cnt_r <= iss_cnt_r + 1'b1;
      end
      if (((state_r == S_MAC) || (state_r == S_UPD)) && mul_out_vld) begin
        res_cnt_r <= pass_last ? '0 : res_cnt_r + 1'b1;
      end
      if ((state_r == S_UPD) && mul_out_vld) begin
        w_vld_r[res_cnt_r] <= 1'b1;
      end
      if ((state_r == S_SWAIT) && mul_out_vld) begin
        iss_cnt_r <= '0;
      end
      if (err_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // multiplier results only come back while a pass or the step scaling waits for them
  a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mul_out_vld |-> ((state_r == S_MAC) || (state_r == S_SWAIT) || (state_r == S_UPD)))
    else $error("multiplier result outside a pass");

  // never more taps issued than exist
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_cnt_r <= CW'(TAPS))
    else $error("tap issue count overrun");

  // an accepted item blocks the input until its work is done
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input accepted while busy");

  // the error is loaded only when the output register is free or draining
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    err_load |-> (!out_vld_r || out_tready))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

FILE: design/lmsanc_q15mul.sv
// shared rounded q15 multiplier, two register stages
`timescale 1ns / 1ps
`default_nettype none

module lmsanc_q15mul
  import lmsanc_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        op_valid,
  input  wire  signed [MUL_A_W-1:0]  op_a,
  input  wire  signed [MUL_B_W-1:0]  op_b,
  output logic                       res_valid,
  output logic        [ACC_W-1:0]    res_q
);

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic        [PROD_W-1:0] rnd_sum;
  logic                     prod_vld_r;
  logic        [ACC_W-1:0]  q_r;
  logic                     q_vld_r;

  // full signed product
  assign prod_nxt = op_a * op_b;

  // add one half lsb, arithmetic shift by q bits, keep the low word
  assign rnd_sum = prod_r + PROD_W'(Q_HALF);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    q_r    <= rnd_sum[Q_BITS+ACC_W-1:Q_BITS];
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      q_vld_r    <= 1'b0;
    end else begin
      prod_vld_r <= op_valid;
      q_vld_r    <= prod_vld_r;
    end
  end

  assign res_valid = q_vld_r;
  assign res_q     = q_r;

endmodule

`default_nettype wire
